// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// default clock and reset names
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Types and constants shared by the wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned OFF_W      = 7;
  localparam int unsigned ALIGN_W    = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_RESULT_OFFSET  = 3'd1,
    CFG_ALIGN_SIZE     = 3'd2,
    CFG_MUST_FIND      = 3'd3,
    CFG_RANGE_BASE     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_PATTERN = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MISSING   = 2'd2,
    ST_TWICE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEEN_NONE = 2'd0,
    SEEN_ONE  = 2'd1,
    SEEN_MANY = 2'd2
  } seen_e;

  typedef struct packed {
    logic              wild;
    logic [BYTE_W-1:0] value;
  } pat_entry_t;

  typedef struct packed {
    logic shift;
    logic tail;
    logic active;
    logic pat_we;
  } cell_ctl_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;
    logic [SLOT_W-1:0] pattern_slot;
    logic [BYTE_W-1:0] pattern_value;
    logic              pattern_wild;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] match_address;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wbps_stream_if.sv =====
// ----------------------------------------------------------------------------
// wbps_stream_if
// Valid/ready stream carrying one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_stream_if #(
  parameter type word_t = logic
);

  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/wildcard_byte_pattern_search_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit
// Wildcard byte pattern search on a byte stream, one word per unstalled cycle.
// ----------------------------------------------------------------------------
// Takes one word per clock, data or pattern load, back to back unless stalled.
// Data bytes enter a chain of MAX_PATTERN_LEN cells at the cell set by
// pattern_length and move one cell towards the oldest end per byte; every
// cell compares its byte with its pattern entry in parallel, and the AND of
// the row is judged in the next cycle, so a range's result passes from the
// compare stage to the output register. Input stalls only while a result
// waits downstream and another last byte is ready behind it. Pattern slots at
// or beyond MAX_PATTERN_LEN are dropped. pattern_length is to be changed
// between ranges, as the chain only holds the bytes that the current length
// needs.
`default_nettype none

`include "assert_macros.svh"

module wildcard_byte_pattern_search_unit #(
  parameter int unsigned MAX_PATTERN_LEN = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  wbps_stream_if.sink                       in_i,
  wbps_stream_if.source                     out_o
);

  import wbps_pkg::*;

  localparam int unsigned IdxW    = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned AdjW    = OFF_W + 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN_LEN);
  localparam logic [IdxW-1:0]  MaxIdx = IdxW'(MAX_PATTERN_LEN - 1);

  // configuration
  logic [LEN_W-1:0]   pat_len_q, pat_len_d;
  logic [OFF_W-1:0]   res_off_q, res_off_d;
  logic [ALIGN_W-1:0] align_q, align_d;
  logic               must_find_q, must_find_d;
  logic [ADDR_W-1:0]  base_q, base_d;

  // values derived from configuration
  logic [IdxW-1:0]    lenm1_q, lenm1_d;
  logic [ADDR_W-1:0]  start_q, start_d;
  logic [ADDR_W-1:0]  start_off_q, start_off_d;
  logic [AdjW-1:0]    off_adj;
  logic [ALIGN_W-1:0] align_mask_q, align_mask_d;
  logic               align_zero_q, align_zero_d;

  // input side
  logic               in_ready, in_acc, data_acc, pat_acc;
  logic [ADDR_W-1:0]  bp_q, bp_d;

  // compare stage
  logic               s1_valid_q, s1_valid_d;
  logic               s1_last_q, s1_ok_q;
  logic [ADDR_W-1:0]  s1_addr_q, s1_addr_off_q;
  logic               s1_fire, chain_hit, aligned, take;

  // search state
  seen_e              seen_q, seen_d, seen_nx;
  logic               done_q, done_d, done_nx;
  logic [ADDR_W-1:0]  first_off_q, first_off_d, first_nx;

  // output register
  logic               out_free;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, res_word;

  // --------------------------------------------------------------------------
  // configuration writes
  always_comb begin
    pat_len_d   = pat_len_q;
    res_off_d   = res_off_q;
    align_d     = align_q;
    must_find_d = must_find_q;
    base_d      = base_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LENGTH: pat_len_d   = cfg_wdata_i[LEN_W-1:0];
        CFG_RESULT_OFFSET:  res_off_d   = cfg_wdata_i[OFF_W-1:0];
        CFG_ALIGN_SIZE:     align_d     = cfg_wdata_i[ALIGN_W-1:0];
        CFG_MUST_FIND:      must_find_d = cfg_wdata_i[0];
        CFG_RANGE_BASE:     base_d      = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pat_len_d == '0) begin
      lenm1_d = '0;
    end else if (pat_len_d > MaxLen) begin
      lenm1_d = MaxIdx;
    end else begin
      lenm1_d = IdxW'(pat_len_d - LEN_W'(1));
    end
    start_d      = base_d - ADDR_W'(lenm1_d);
    off_adj      = {1'b0, res_off_d} - AdjW'(lenm1_d);
    start_off_d  = base_d + {{(ADDR_W-AdjW){off_adj[AdjW-1]}}, off_adj};
    align_mask_d = align_d - ALIGN_W'(1);
    align_zero_d = (align_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q    <= LEN_W'(1);
      res_off_q    <= '0;
      align_q      <= '0;
      must_find_q  <= 1'b0;
      base_q       <= '0;
      lenm1_q      <= '0;
      start_q      <= '0;
      start_off_q  <= '0;
      align_mask_q <= '1;
      align_zero_q <= 1'b1;
    end else begin
      pat_len_q    <= pat_len_d;
      res_off_q    <= res_off_d;
      align_q      <= align_d;
      must_find_q  <= must_find_d;
      base_q       <= base_d;
      lenm1_q      <= lenm1_d;
      start_q      <= start_d;
      start_off_q  <= start_off_d;
      align_mask_q <= align_mask_d;
      align_zero_q <= align_zero_d;
    end
  end

  // --------------------------------------------------------------------------
  // input handshake and byte position
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready = !s1_valid_q || s1_fire;
  assign in_acc   = in_i.valid && in_ready;
  assign data_acc = in_acc && (in_i.word.kind == KIND_DATA);
  assign pat_acc  = in_acc && (in_i.word.kind == KIND_PATTERN);

  assign in_i.ready = in_ready;

  always_comb begin
    bp_d = bp_q;
    if (data_acc) begin
      bp_d = in_i.word.is_last ? '0 : bp_q + ADDR_W'(1);
    end
    s1_valid_d = s1_valid_q;
    if (data_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      bp_q       <= bp_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      s1_last_q     <= in_i.word.is_last;
      s1_ok_q       <= (|bp_q[ADDR_W-1:IdxW]) || (bp_q[IdxW-1:0] >= lenm1_q);
      s1_addr_q     <= start_q + bp_q;
      s1_addr_off_q <= start_off_q + bp_q;
    end
  end

  wbps_chain #(
    .MAX_LEN (MAX_PATTERN_LEN),
    .IDX_W   (IdxW)
  ) u_chain (
    .clk_i    (clk_i),
    .shift_i  (data_acc),
    .pat_we_i (pat_acc),
    .byte_i   (in_i.word.data_byte),
    .slot_i   (in_i.word.pattern_slot),
    .pat_i    ({in_i.word.pattern_wild, in_i.word.pattern_value}),
    .lenm1_i  (lenm1_q),
    .hit_o    (chain_hit)
  );

  // --------------------------------------------------------------------------
  // match decision and result
  always_comb begin
    aligned = align_zero_q || ((s1_addr_q[ALIGN_W-1:0] & align_mask_q) == '0);
    take    = s1_valid_q && !done_q && s1_ok_q && chain_hit && aligned;

    case (seen_q)
      SEEN_NONE: begin
        seen_nx = SEEN_NONE;
        if (take) begin
          seen_nx = SEEN_ONE;
        end
      end
      SEEN_ONE: begin
        seen_nx = SEEN_ONE;
        if (take) begin
          seen_nx = SEEN_MANY;
        end
      end
      default:   seen_nx = SEEN_MANY;
    endcase
    first_nx = (take && (seen_q == SEEN_NONE)) ? s1_addr_off_q : first_off_q;
    done_nx  = done_q || (take && !align_zero_q);

    case (seen_nx)
      SEEN_ONE: begin
        res_word.status        = ST_FOUND;
        res_word.match_address = first_nx;
      end
      SEEN_NONE: begin
        res_word.status        = ST_NOT_FOUND;
        if (must_find_q) begin
          res_word.status = ST_MISSING;
        end
        res_word.match_address = '0;
      end
      default: begin
        res_word.status        = ST_TWICE;
        res_word.match_address = '0;
      end
    endcase
  end

  always_comb begin
    seen_d      = seen_q;
    done_d      = done_q;
    first_off_d = first_off_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        seen_d      = SEEN_NONE;
        done_d      = 1'b0;
        first_off_d = '0;
      end else begin
        seen_d      = seen_nx;
        done_d      = done_nx;
        first_off_d = first_nx;
      end
    end
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= SEEN_NONE;
      done_q      <= 1'b0;
      first_off_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      done_q      <= done_d;
      first_off_q <= first_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_word_q <= res_word;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // --------------------------------------------------------------------------
  `ASSERT_DEF(a_result_from_last, $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q), "stray result")
  `ASSERT_DEF(a_state_cleared, $past(s1_fire && s1_last_q) |-> (seen_q == SEEN_NONE) && !done_q, "state kept")
  `ASSERT_DEF(a_stall_cause, !in_ready |-> s1_valid_q && s1_last_q && !out_free, "stall without result")

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// One window byte and one pattern entry, with the per-position compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell (
  input  logic                                clk_i,
  input  wbps_pkg::cell_ctl_t                 ctl_i,
  input  logic [wbps_pkg::BYTE_W-1:0]         byte_i,
  input  logic [wbps_pkg::BYTE_W-1:0]         nbr_i,
  input  wbps_pkg::pat_entry_t                pat_i,
  output logic [wbps_pkg::BYTE_W-1:0]         win_o,
  output logic                                hit_o
);

  import wbps_pkg::*;

  logic [BYTE_W-1:0] win_q, win_d;
  pat_entry_t        pat_q;

  // tail cell takes the new byte, the others take their upper neighbour
  assign win_d = ctl_i.tail ? byte_i : nbr_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      win_q <= win_d;
    end
    if (ctl_i.pat_we) begin
      pat_q <= pat_i;
    end
  end

  assign win_o = win_q;
  assign hit_o = !ctl_i.active || pat_q.wild || (pat_q.value == win_q);

endmodule

`default_nettype wire

// ===== hw/rtl/wbps_chain.sv =====
// ----------------------------------------------------------------------------
// wbps_chain
// Row of compare cells; oldest byte sits at cell 0, newest at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_chain #(
  parameter int unsigned MAX_LEN = 64,
  parameter int unsigned IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic                          pat_we_i,
  input  logic [wbps_pkg::BYTE_W-1:0]   byte_i,
  input  logic [wbps_pkg::SLOT_W-1:0]   slot_i,
  input  wbps_pkg::pat_entry_t          pat_i,
  input  logic [IDX_W-1:0]              lenm1_i,
  output logic                          hit_o
);

  import wbps_pkg::*;

  localparam int unsigned SlotCnt = 2 ** SLOT_W;

  logic [BYTE_W-1:0]  win [MAX_LEN];
  logic [MAX_LEN-1:0] hits;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    cell_ctl_t         ctl;
    logic [BYTE_W-1:0] nbr;

    assign ctl.shift  = shift_i;
    assign ctl.tail   = (lenm1_i == IDX_W'(i));
    assign ctl.active = (IDX_W'(i) <= lenm1_i);

    if (i < SlotCnt) begin : g_we
      assign ctl.pat_we = pat_we_i && (slot_i == SLOT_W'(i));
    end else begin : g_no_we
      assign ctl.pat_we = 1'b0;
    end

    if (i == MAX_LEN - 1) begin : g_top
      assign nbr = byte_i;
    end else begin : g_mid
      assign nbr = win[i+1];
    end

    wbps_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .byte_i (byte_i),
      .nbr_i  (nbr),
      .pat_i  (pat_i),
      .win_o  (win[i]),
      .hit_o  (hits[i])
    );
  end

  assign hit_o = &hits;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard byte pattern search unit.
// ----------------------------------------------------------------------------
// Pattern and data words go in through a valid/ready stream with random gaps,
// and the search reports come out through another with random back-pressure.
// An in-bench model of the window compare predicts the phase reports. A short
// directed table opens the run, then phases with fresh register settings
// send ranges with planted patterns, noise bytes and pattern loads mid-range.
// ----------------------------------------------------------------------------
module testbench;
  import wbps_pkg::*;

  localparam int unsigned MAX_LEN      = 64;
  localparam int unsigned WORD_BITS    = $bits(in_word_t);
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned FEED_TARGET  = 1000;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] value;
    logic              wild;
    logic              typed;
    status_e           status;
    logic [ADDR_W-1:0] addr;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  wbps_stream_if #(.word_t(in_word_t))  in_if ();
  wbps_stream_if #(.word_t(out_word_t)) out_if ();

  wildcard_byte_pattern_search_unit #(
    .MAX_PATTERN_LEN(MAX_LEN)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // search model state
  logic [BYTE_W-1:0] recent [MAX_LEN];
  pat_entry_t        pattern_mem [MAX_LEN];
  logic [ADDR_W-1:0] scan_pos;
  logic [ADDR_W-1:0] first_hit;
  seen_e             hits;
  bit                locked;
  logic [LEN_W-1:0]   reg_len;
  logic [OFF_W-1:0]   reg_off;
  logic [ALIGN_W-1:0] reg_align;
  logic               reg_must;
  logic [ADDR_W-1:0]  reg_base;

  out_word_t   awaited_reports [$];
  int unsigned mismatches;
  int unsigned items_fed;
  int unsigned reports_taken;
  int unsigned tx_seq, rx_seq;
  bit          tx_calm, rx_calm;

  step_row_t steps [14] = '{
    '{KIND_PATTERN, 8'h00, 1'b0, 6'd0,  8'hA5, 1'b0, 1'b0, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'h00, 1'b1, 6'd63, 8'h00, 1'b1, 1'b1, ST_NOT_FOUND, 64'd0},
    '{KIND_DATA,    8'hA5, 1'b1, 6'd0,  8'hFF, 1'b0, 1'b1, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'hFF, 1'b0, 6'd21, 8'h2A, 1'b1, 1'b0, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'hA5, 1'b0, 6'd42, 8'h55, 1'b0, 1'b0, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'hA5, 1'b1, 6'd63, 8'hFF, 1'b1, 1'b1, ST_TWICE,     64'd0},
    '{KIND_PATTERN, 8'hFF, 1'b1, 6'd63, 8'hFF, 1'b1, 1'b0, ST_FOUND,     64'd0},
    '{KIND_PATTERN, 8'h00, 1'b0, 6'd0,  8'h00, 1'b1, 1'b0, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'h5A, 1'b1, 6'd0,  8'h00, 1'b0, 1'b1, ST_FOUND,     64'd0},
    '{KIND_PATTERN, 8'h00, 1'b0, 6'd0,  8'hFF, 1'b0, 1'b0, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'hFF, 1'b0, 6'd63, 8'h00, 1'b1, 1'b0, ST_FOUND,     64'd0},
    '{KIND_PATTERN, 8'hFF, 1'b1, 6'd0,  8'h00, 1'b0, 1'b0, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'hFF, 1'b1, 6'd0,  8'hFF, 1'b0, 1'b1, ST_FOUND,     64'd0},
    '{KIND_DATA,    8'h00, 1'b1, 6'd63, 8'hFF, 1'b1, 1'b1, ST_FOUND,     64'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_len(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_LEN) return MAX_LEN;
    return len;
  endfunction

  function automatic void clear_scan();
    foreach (recent[i]) recent[i] = '0;
    scan_pos  = '0;
    first_hit = '0;
    hits      = SEEN_NONE;
    locked    = 1'b0;
  endfunction

  function automatic void search_step(input in_word_t w, output bit emit, output out_word_t r);
    int unsigned       n;
    bit                hit;
    logic [ADDR_W-1:0] at;
    emit = 1'b0;
    r    = '0;
    if (w.kind == KIND_PATTERN) begin
      pattern_mem[w.pattern_slot].wild  = w.pattern_wild;
      pattern_mem[w.pattern_slot].value = w.pattern_value;
      return;
    end
    for (int i = MAX_LEN - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = w.data_byte;
    if (!locked) begin
      n = clamp_len(reg_len);
      if (scan_pos >= 64'(n - 1)) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++)
          if (!pattern_mem[i].wild && pattern_mem[i].value != recent[n-1-i]) hit = 1'b0;
        if (hit) begin
          at = reg_base + scan_pos - 64'(n - 1);
          if (reg_align == 0 || (at & (64'(reg_align) - 64'd1)) == 0) begin
            if (hits == SEEN_NONE) begin
              first_hit = at;
              hits      = SEEN_ONE;
              if (reg_align != 0) locked = 1'b1;
            end else begin
              hits = SEEN_MANY;
            end
          end
        end
      end
    end
    scan_pos = scan_pos + 64'd1;
    if (!w.is_last) return;
    emit = 1'b1;
    case (hits)
      SEEN_ONE: begin
        r.status        = ST_FOUND;
        r.match_address = first_hit + 64'(reg_off);
      end
      SEEN_NONE: begin
        r.status        = ST_NOT_FOUND;
        if (reg_must) r.status = ST_MISSING;
        r.match_address = '0;
      end
      default: begin
        r.status        = ST_TWICE;
        r.match_address = '0;
      end
    endcase
    clear_scan();
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned seq, inout bit calm);
    seq++;
    if (seq % 48 == 0) calm = ($urandom_range(0, 2) == 0);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  task automatic feed(input in_word_t w, input bit typed, input out_word_t fixed);
    int unsigned gap;
    bit          emit;
    out_word_t   r;
    gap = draw_gap(tx_seq, tx_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.word  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    items_fed++;
    search_step(w, emit, r);
    if (emit) awaited_reports.push_back(typed ? fixed : r);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
  endtask

  task automatic set_registers(input logic [LEN_W-1:0] len, input logic [OFF_W-1:0] off,
                               input logic [ALIGN_W-1:0] align, input logic must,
                               input logic [ADDR_W-1:0] base);
    put_reg(CFG_PATTERN_LENGTH, 64'(len));
    put_reg(CFG_RESULT_OFFSET, 64'(off));
    put_reg(CFG_ALIGN_SIZE, 64'(align));
    put_reg(CFG_MUST_FIND, 64'(must));
    put_reg(CFG_RANGE_BASE, base);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    reg_len   = len;
    reg_off   = off;
    reg_align = align;
    reg_must  = must;
    reg_base  = base;
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input logic [OFF_W-1:0] off,
                           input logic [ALIGN_W-1:0] align, input logic must,
                           input logic [ADDR_W-1:0] base, input int unsigned ranges);
    logic [BYTE_W-1:0] alpha [4];
    pat_entry_t        plan [MAX_LEN];
    logic [BYTE_W-1:0] bytes [$];
    int unsigned       eff, n, at;
    logic [ADDR_W-1:0] need;
    in_word_t          w;
    settle();
    set_registers(len, off, align, must, base);
    eff = clamp_len(len);
    foreach (alpha[i]) alpha[i] = 8'($urandom);
    for (int s = 0; s < eff; s++) begin
      plan[s].value = ($urandom_range(0, 7) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 3)];
      plan[s].wild  = ($urandom_range(0, 5) == 0);
      w               = WORD_BITS'($urandom);
      w.kind          = KIND_PATTERN;
      w.pattern_slot  = SLOT_W'(s);
      w.pattern_value = plan[s].value;
      w.pattern_wild  = plan[s].wild;
      feed(w, 1'b0, '0);
    end
    repeat (ranges) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, eff + 80) : $urandom_range(1, eff + 12);
      bytes.delete();
      repeat (n)
        bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 3)]);
      // plant the pattern up to twice, at times at an aligned address where one fits
      if (n >= eff) repeat ($urandom_range(0, 2)) begin
        at   = $urandom_range(0, n - eff);
        need = (64'd0 - base) & (64'(align) - 64'd1);
        if (align != 0 && $urandom_range(0, 1) == 1 && need <= 64'(n - eff)) at = 32'(need);
        for (int i = 0; i < eff; i++) if (!plan[i].wild) bytes[at + i] = plan[i].value;
      end
      foreach (bytes[j]) begin
        if ($urandom_range(0, 15) == 0) begin
          w      = WORD_BITS'($urandom);
          w.kind = KIND_PATTERN;
          if (w.pattern_slot < eff) begin
            plan[w.pattern_slot].wild  = w.pattern_wild;
            plan[w.pattern_slot].value = w.pattern_value;
          end
          feed(w, 1'b0, '0);
        end
        w           = WORD_BITS'($urandom);
        w.kind      = KIND_DATA;
        w.data_byte = bytes[j];
        w.is_last   = (j == n - 1);
        feed(w, 1'b0, '0);
      end
    end
  endtask

  // report side
  initial begin : report_sink
    int unsigned gap;
    out_word_t   got, want;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = (reports_taken == 2 || reports_taken == 60) ? HOLD_CYCLES
                                                        : draw_gap(rx_seq, rx_calm);
      if (gap > 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = out_if.word;
      reports_taken++;
      if (awaited_reports.size() == 0) begin
        flag_mismatch($sformatf("report with no search pending: status %0d address %h",
                                got.status, got.match_address));
      end else begin
        want = awaited_reports.pop_front();
        if (got.status !== want.status)
          flag_mismatch($sformatf("report %0d status: expected %0d, got %0d",
                                  reports_taken, want.status, got.status));
        if (got.match_address !== want.match_address)
          flag_mismatch($sformatf("report %0d address: expected %h, got %h",
                                  reports_taken, want.match_address, got.match_address));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    in_word_t           w;
    out_word_t          fixed;
    int unsigned        pick;
    logic [LEN_W-1:0]   len;
    logic [ALIGN_W-1:0] align;
    logic [ADDR_W-1:0]  base;
    in_if.valid = 1'b0;
    in_if.word  = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PATTERN_LENGTH;
    cfg_wdata_i = '0;
    reg_len     = 7'd1;
    reg_off     = '0;
    reg_align   = '0;
    reg_must    = 1'b0;
    reg_base    = '0;
    foreach (pattern_mem[i]) pattern_mem[i] = '0;
    clear_scan();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (steps[k]) begin
      w.kind                = steps[k].kind;
      w.data_byte           = steps[k].data;
      w.is_last             = steps[k].last;
      w.pattern_slot        = steps[k].slot;
      w.pattern_value       = steps[k].value;
      w.pattern_wild        = steps[k].wild;
      fixed.status          = steps[k].status;
      fixed.match_address   = steps[k].addr;
      feed(w, steps[k].typed, fixed);
    end

    // full length, address wrap, required match
    run_phase(7'd64, 7'd65, 13'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFC0, 3);
    // length zero, widest alignment
    run_phase(7'd0, 7'd0, 13'd4096, 1'b0, {$urandom, $urandom} & ~64'hFFF, 4);
    // length above the maximum, alignment not a power of two
    run_phase(7'd127, 7'd1, 13'd3, 1'b1, 64'd0, 3);
    run_phase(7'd2, 7'd0, 13'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 5);
    run_phase(7'd1, 7'd0, 13'd1, 1'b1, 64'd0, 5);

    while (items_fed < FEED_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)     len = 7'($urandom_range(65, 127));
      else if (pick == 1) len = 7'd0;
      else if (pick < 4) len = 7'($urandom_range(9, 64));
      else               len = 7'($urandom_range(1, 8));
      pick = $urandom_range(0, 5);
      if (pick < 2)      align = '0;
      else if (pick < 5) align = 13'(1 << $urandom_range(0, 12));
      else               align = 13'($urandom_range(1, 4096));
      base = ($urandom_range(0, 3) == 0) ? {32'hFFFF_FFFF, $urandom} : {$urandom, $urandom};
      run_phase(len, 7'($urandom_range(0, 65)), align, 1'($urandom_range(0, 1)), base,
                $urandom_range(3, 8));
    end

    settle();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
